### rtl/core/cifc_pkg.sv
// shared types and constants for the cray / ieee float converter
package cifc_pkg;

   // conversion codes carried in the mode field
   localparam logic [2:0] MODE_S_TO_CRAY = 3'd0;
   localparam logic [2:0] MODE_D_TO_CRAY = 3'd1;
   localparam logic [2:0] MODE_Q_TO_CRAY = 3'd2;
   localparam logic [2:0] MODE_CRAY_TO_S = 3'd3;
   localparam logic [2:0] MODE_CRAY_TO_D = 3'd4;
   localparam logic [2:0] MODE_CRAY_TO_Q = 3'd5;

   localparam int MODE_WIDTH  = 3;
   localparam int WORD_WIDTH  = 64;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // exponent limits and biases
   localparam logic [14:0] CRAY_EXP_MAX = 15'd24576;
   localparam int          CRAY_BIAS    = 16384;
   localparam int          Q_EXP_MAX    = 32767;
   localparam int          Q_BIAS       = 16383;
   localparam int          D_EXP_MAX    = 2047;
   localparam int          D_BIAS       = 1023;
   localparam int          S_EXP_MAX    = 255;
   localparam int          S_BIAS       = 127;

   // exponent offsets toward the cray field
   localparam logic [15:0] S_TO_CRAY_OFS = 16'(CRAY_BIAS - S_BIAS + 1);
   localparam logic [15:0] D_TO_CRAY_OFS = 16'(CRAY_BIAS - D_BIAS + 1);
   localparam logic [15:0] Q_TO_CRAY_OFS = 16'(CRAY_BIAS - Q_BIAS + 1);

   // cray exponent thresholds toward ieee
   localparam logic [14:0] S_UNF_EXP = 15'(CRAY_BIAS - S_BIAS + 2);
   localparam logic [14:0] S_OVF_EXP = 15'(CRAY_BIAS - S_BIAS + 2 + S_EXP_MAX - 1);
   localparam logic [14:0] D_UNF_EXP = 15'(CRAY_BIAS - D_BIAS + 2);
   localparam logic [14:0] D_OVF_EXP = 15'(CRAY_BIAS - D_BIAS + 2 + D_EXP_MAX - 1);
   localparam logic [14:0] Q_UNF_EXP = 15'd3;

   // mantissa patterns
   localparam logic [47:0] NORM_BIT = 48'h8000_0000_0000;
   localparam logic [47:0] NAN_MAN  = 48'h00_3C4E_614E_3E;
   localparam logic [63:0] WIDE_NAN = 64'h8000_0000_0000_0000 | ({16'd0, NAN_MAN} << 16);

   typedef struct packed {
      logic [WORD_WIDTH-1:0] result_hi;
      logic [WORD_WIDTH-1:0] result_lo;
      logic                  overflow_seen;
   } result_type;

endpackage

### rtl/core/cifc_if.sv
// request and response channel interfaces
interface cifc_req_if;
   import cifc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MODE_WIDTH-1:0] mode;
   logic [WORD_WIDTH-1:0] word_hi;
   logic [WORD_WIDTH-1:0] word_lo;

   modport source (output valid, output mode, output word_hi, output word_lo, input ready);
   modport sink   (input valid, input mode, input word_hi, input word_lo, output ready);
endinterface

interface cifc_rsp_if;
   import cifc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] result_hi;
   logic [WORD_WIDTH-1:0] result_lo;
   logic                  overflow_seen;

   modport source (output valid, output result_hi, output result_lo, output overflow_seen,
                   input ready);
   modport sink   (input valid, input result_hi, input result_lo, input overflow_seen,
                   output ready);
endinterface

### rtl/core/cray_ieee_float_converter.sv
// top level of the cray / ieee float converter with overflow counter
//
//  channel   dir   signals                                   transfer when
//  req_chan  in    mode, word_hi, word_lo                    valid && ready
//  rsp_chan  out   result_hi, result_lo, overflow_seen       valid && ready
//  csr       in    csr_write_en, csr_write_data (count_overflows)  write_en high
//
//  one item per cycle sustained while the receiver holds ready high; a request
//  passes from the input register through the conversion logic into the result
//  register, which offers it on rsp_chan
//  reset is synchronous, active high: both stages empty, counting enabled, count zero
//  a stalled result holds in the result register while the input register still takes
//  one more item; the input side stalls only when both registers are full
module cray_ieee_float_converter #(
   parameter int COUNT_WIDTH = cifc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   cifc_req_if.sink          req_chan,
   cifc_rsp_if.source        rsp_chan,
   input  logic              csr_write_en,
   input  logic              csr_write_data
);
   import cifc_pkg::*;

   // input register stage
   logic                  in_valid_ff;
   logic [MODE_WIDTH-1:0] in_mode_ff;
   logic [WORD_WIDTH-1:0] in_hi_ff;
   logic [WORD_WIDTH-1:0] in_lo_ff;

   // result register stage
   logic                  out_valid_ff;
   result_type            out_result_ff;
   result_type            conv_in;

   // control and status
   logic                   count_overflows_ff;
   logic [COUNT_WIDTH-1:0] overflow_count_ff;
   logic [COUNT_WIDTH-1:0] overflow_count_in;

   logic out_advance;
   logic in_advance;
   logic req_xfer;

   // result register frees up when empty or when its transfer completes
   assign out_advance = !out_valid_ff || rsp_chan.ready;
   // input register moves on into the result register
   assign in_advance  = in_valid_ff && out_advance;
   assign req_chan.ready = !in_valid_ff || out_advance;
   assign req_xfer    = req_chan.valid && req_chan.ready;

   cifc_convert u_convert (
      .mode    (in_mode_ff),
      .word_hi (in_hi_ff),
      .word_lo (in_lo_ff),
      .result  (conv_in)
   );

   // saturating count of true overflows, taken as the item enters the result register
   always_comb begin
      overflow_count_in = overflow_count_ff;
      if (in_advance && conv_in.overflow_seen && count_overflows_ff
          && !(&overflow_count_ff)) begin
         overflow_count_in = overflow_count_ff + COUNT_WIDTH'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         count_overflows_ff <= 1'b1;
         overflow_count_ff  <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_write_en) begin
            count_overflows_ff <= csr_write_data;
         end
         overflow_count_ff <= overflow_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_mode_ff <= req_chan.mode;
         in_hi_ff   <= req_chan.word_hi;
         in_lo_ff   <= req_chan.word_lo;
      end
      if (in_advance) begin
         out_result_ff <= conv_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.result_hi     = out_result_ff.result_hi;
   assign rsp_chan.result_lo     = out_result_ff.result_lo;
   assign rsp_chan.overflow_seen = out_result_ff.overflow_seen;

endmodule

### rtl/core/cifc_convert.sv
// combinational conversion of one word in any of the six modes
module cifc_convert (
   input  logic [2:0]           mode,
   input  logic [63:0]          word_hi,
   input  logic [63:0]          word_lo,
   output cifc_pkg::result_type result
);
   import cifc_pkg::*;

   // ieee to cray side
   logic        to_sign;
   logic        is_max;
   logic        is_zero;
   logic        is_nan;
   logic [15:0] to_exp;
   logic [63:0] wide;
   logic [49:0] rnd_sum;
   logic [48:0] man49;
   logic [15:0] exp_tot;
   logic [63:0] cray_word;

   // cray to ieee side
   logic [14:0] c_exp;
   logic        c_finite;
   logic [15:0] s_diff;
   logic [15:0] d_diff;
   logic [25:0] s_rnd;
   logic [30:0] s_body;
   logic [62:0] d_body;

   always_comb begin
      to_sign = word_hi[63];
      is_max  = 1'b0;
      is_zero = 1'b0;
      is_nan  = 1'b0;
      to_exp  = 16'd0;
      wide    = 64'd0;
      case (mode)
         MODE_S_TO_CRAY: begin
            to_sign = word_hi[31];
            is_max  = word_hi[30:23] == 8'(S_EXP_MAX);
            is_zero = word_hi[30:23] == 8'd0;
            is_nan  = word_hi[22:0] != 23'd0;
            to_exp  = {8'd0, word_hi[30:23]} + S_TO_CRAY_OFS;
            // single keeps its mantissa exactly, no round term below bit 15
            wide    = {1'b1, word_hi[22:0], 40'd0};
         end
         MODE_D_TO_CRAY: begin
            is_max  = word_hi[62:52] == 11'(D_EXP_MAX);
            is_zero = word_hi[62:52] == 11'd0;
            is_nan  = word_hi[51:0] != 52'd0;
            to_exp  = {5'd0, word_hi[62:52]} + D_TO_CRAY_OFS;
            wide    = {1'b1, word_hi[51:0], 11'd0};
         end
         default: begin
            is_max  = word_hi[62:48] == 15'(Q_EXP_MAX);
            is_zero = word_hi[62:48] == 15'd0;
            is_nan  = (word_hi[47:0] != 48'd0) || (word_lo != 64'd0);
            to_exp  = {1'b0, word_hi[62:48]} + Q_TO_CRAY_OFS;
            wide    = {1'b1, word_hi[47:0], 15'd0};
         end
      endcase

      if (is_max) begin
         to_exp = {1'b0, CRAY_EXP_MAX};
      end

      // single nan takes the pattern unrounded, wide formats round it
      if (mode == MODE_S_TO_CRAY) begin
         rnd_sum = 50'd0;
         man49   = {1'b0, NORM_BIT | ((is_max && is_nan) ? NAN_MAN
                                                         : {1'b0, word_hi[22:0], 24'd0})};
         if (is_max && !is_nan) begin
            man49 = {1'b0, NORM_BIT};
         end
      end else begin
         rnd_sum = {1'b0, ((is_max && is_nan) ? WIDE_NAN[63:15] : wide[63:15])} + 50'd1;
         man49   = {rnd_sum[49], rnd_sum[48:1] | NORM_BIT};
      end

      exp_tot = to_exp + {15'd0, man49[48]};
      if (is_zero) begin
         cray_word = 64'd0;
      end else if (exp_tot[15]) begin
         cray_word = {to_sign, CRAY_EXP_MAX, NORM_BIT};
      end else begin
         cray_word = {to_sign, exp_tot[14:0], man49[47:0]};
      end

      // cray to ieee
      c_exp    = word_hi[62:48];
      c_finite = c_exp < CRAY_EXP_MAX;
      s_diff   = {1'b0, c_exp} - {1'b0, S_UNF_EXP};
      d_diff   = {1'b0, c_exp} - {1'b0, D_UNF_EXP};
      s_rnd    = ({1'b0, word_hi[47:23]} + 26'd1) >> 1;
      s_body   = {s_diff[7:0], 23'd0} + {5'd0, s_rnd};
      d_body   = {d_diff[10:0], 52'd0} + {10'd0, word_hi[47:0], 5'd0};

      result = '0;
      case (mode)
         MODE_S_TO_CRAY, MODE_D_TO_CRAY, MODE_Q_TO_CRAY: begin
            result.result_hi = cray_word;
         end
         MODE_CRAY_TO_S: begin
            if (c_exp >= S_OVF_EXP) begin
               result.result_hi     = {32'd0, word_hi[63], 8'(S_EXP_MAX), 23'd0};
               result.overflow_seen = c_finite;
            end else if (c_exp < S_UNF_EXP) begin
               result.result_hi = {32'd0, word_hi[63], 31'd0};
            end else begin
               result.result_hi = {32'd0, word_hi[63], s_body};
            end
         end
         MODE_CRAY_TO_D: begin
            if (c_exp >= D_OVF_EXP) begin
               result.result_hi     = {word_hi[63], 11'(D_EXP_MAX), 52'd0};
               result.overflow_seen = c_finite;
            end else if (c_exp < D_UNF_EXP) begin
               result.result_hi = {word_hi[63], 63'd0};
            end else begin
               result.result_hi = {word_hi[63], d_body};
            end
         end
         MODE_CRAY_TO_Q: begin
            if (!c_finite) begin
               result.result_hi = {word_hi[63], 15'(Q_EXP_MAX), 48'd0};
            end else if (c_exp < Q_UNF_EXP) begin
               result.result_hi = {word_hi[63], 63'd0};
            end else begin
               result.result_hi = {word_hi[63], c_exp - 15'd2, word_hi[46:0], 1'b0};
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

### tb/cifc_conversion_checker.sv
// checker for the cray / ieee float converter: predicts each conversion and compares results
`timescale 1ns / 1ps

module cifc_conversion_checker (
   input  logic        clock,
   input  logic        reset,
   cifc_req_if         req_mon,
   cifc_rsp_if         rsp_mon,
   input  logic        csr_write_en,
   input  logic        csr_write_data,
   output int unsigned fail_count,
   output int unsigned pending_count,
   output int unsigned checked_count,
   output logic [31:0] overflow_tally
);
   import cifc_pkg::*;

   result_type pending_conversions[$];
   logic       count_enable_mirror;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
      overflow_tally = '0;
      count_enable_mirror = 1'b1;
   end

   // builds a cray word, letting a rounding carry bump the exponent
   function automatic logic [63:0] pack_cray_word(logic sign, logic [63:0] cexp,
                                                  logic [63:0] mant);
      logic [63:0] e;
      e = cexp + (mant >> 48);
      if (e > 64'h7FFF)
         return {sign, CRAY_EXP_MAX, NORM_BIT};
      return {sign, e[14:0], mant[47:0]};
   endfunction

   // left-justified mantissa rounded to 48 bits by adding one half
   function automatic logic [63:0] round_to_cray(logic [63:0] wide);
      return (((wide >> 15) + 64'd1) >> 1) | {16'd0, NORM_BIT};
   endfunction

   function automatic result_type convert_value(logic [2:0] mode, logic [63:0] hi,
                                                logic [63:0] lo);
      result_type  r;
      logic        sign, flag, top_exp, zero_exp, is_nan;
      logic [63:0] cexp, mant, wide, sgn_word;
      logic [14:0] ce;
      logic [7:0]  se;
      int          s;
      r    = '0;
      flag = 1'b0;
      case (mode)
         MODE_S_TO_CRAY: begin
            sign = hi[31];
            se   = hi[30:23];
            if (se == 8'hFF) begin
               cexp = 64'(CRAY_EXP_MAX);
               mant = (hi[22:0] != '0) ? {16'd0, NORM_BIT | NAN_MAN} : {16'd0, NORM_BIT};
            end else if (se == '0) begin
               sign = 1'b0;
               cexp = '0;
               mant = '0;
            end else begin
               cexp = 64'(se) + 64'(CRAY_BIAS - S_BIAS + 1);
               mant = {16'd0, NORM_BIT} | ({41'd0, hi[22:0]} << 24);
            end
            r.result_hi = pack_cray_word(sign, cexp, mant);
         end
         MODE_D_TO_CRAY, MODE_Q_TO_CRAY: begin
            sign = hi[63];
            if (mode == MODE_D_TO_CRAY) begin
               top_exp  = hi[62:52] == 11'h7FF;
               zero_exp = hi[62:52] == '0;
               wide     = {1'b1, hi[51:0], 11'd0};
               is_nan   = hi[51:0] != '0;
               cexp     = 64'(hi[62:52]) + 64'(CRAY_BIAS - D_BIAS + 1);
            end else begin
               top_exp  = hi[62:48] == 15'h7FFF;
               zero_exp = hi[62:48] == '0;
               wide     = {1'b1, hi[47:0], 15'd0};
               is_nan   = hi[47:0] != '0 || lo != '0;
               cexp     = 64'(hi[62:48]) + 64'(CRAY_BIAS - Q_BIAS + 1);
            end
            if (top_exp) begin
               cexp = 64'(CRAY_EXP_MAX);
               mant = round_to_cray(is_nan ? ({NAN_MAN, 16'd0} | {1'b1, 63'd0}) : wide);
            end else if (zero_exp) begin
               sign = 1'b0;
               cexp = '0;
               mant = '0;
            end else begin
               mant = round_to_cray(wide);
            end
            r.result_hi = pack_cray_word(sign, cexp, mant);
         end
         MODE_CRAY_TO_S: begin
            ce       = hi[62:48];
            sgn_word = {32'd0, hi[63], 31'd0};
            s        = int'(ce) + (S_BIAS - CRAY_BIAS - 2);
            if (s >= S_EXP_MAX - 1) begin
               r.result_hi = sgn_word | {33'd0, 8'hFF, 23'd0};
               flag        = ce < CRAY_EXP_MAX;
            end else if (s < 0) begin
               r.result_hi = sgn_word;
            end else begin
               r.result_hi = sgn_word | ((64'(s) << 23) + ((64'(hi[47:23]) + 64'd1) >> 1));
            end
         end
         MODE_CRAY_TO_D: begin
            ce       = hi[62:48];
            sgn_word = {hi[63], 63'd0};
            s        = int'(ce) + (D_BIAS - CRAY_BIAS - 2);
            if (s >= D_EXP_MAX - 1) begin
               r.result_hi = sgn_word | {1'b0, 11'h7FF, 52'd0};
               flag        = ce < CRAY_EXP_MAX;
            end else if (s < 0) begin
               r.result_hi = sgn_word;
            end else begin
               r.result_hi = sgn_word | ((64'(s) << 52) + {11'd0, hi[47:0], 5'd0});
            end
         end
         MODE_CRAY_TO_Q: begin
            ce = hi[62:48];
            if (ce >= CRAY_EXP_MAX)
               r.result_hi = {hi[63], 15'h7FFF, 48'd0};
            else if (ce < 15'd3)
               r.result_hi = {hi[63], 63'd0};
            else
               r.result_hi = {hi[63], ce - 15'd2, hi[46:0], 1'b0};
         end
         default: r = '0;
      endcase
      r.overflow_seen = flag;
      if (flag && count_enable_mirror && overflow_tally != '1)
         overflow_tally = overflow_tally + 32'd1;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want, seen;
      if (reset) begin
         pending_conversions.delete();
         count_enable_mirror = 1'b1;
         overflow_tally      = '0;
      end else begin
         if (csr_write_en)
            count_enable_mirror = csr_write_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.result_hi     = rsp_mon.result_hi;
            seen.result_lo     = rsp_mon.result_lo;
            seen.overflow_seen = rsp_mon.overflow_seen;
            if (pending_conversions.size() == 0) begin
               $error("result transfer with no conversion waiting: hi %h", seen.result_hi);
               fail_count++;
            end else begin
               want = pending_conversions.pop_front();
               checked_count++;
               if (seen.result_hi !== want.result_hi) begin
                  $error("result_hi mismatch: expected %h, got %h",
                         want.result_hi, seen.result_hi);
                  fail_count++;
               end
               if (seen.result_lo !== want.result_lo) begin
                  $error("result_lo mismatch: expected %h, got %h",
                         want.result_lo, seen.result_lo);
                  fail_count++;
               end
               if (seen.overflow_seen !== want.overflow_seen) begin
                  $error("overflow_seen mismatch: expected %b, got %b",
                         want.overflow_seen, seen.overflow_seen);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_conversions.push_back(convert_value(req_mon.mode, req_mon.word_hi,
                                                        req_mon.word_lo));
      end
      pending_count = pending_conversions.size();
   end

endmodule

### tb/tb_top.sv
// top of the cray / ieee float converter testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_top;
   import cifc_pkg::*;

   // mode codes the block has no conversion for
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         PHASE_ITEMS   = 200;
   localparam int         PHASE_COUNT   = 4;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic        csr_write_data;
   logic        idle_on;
   int unsigned fail_count, pending_count, checked_count;
   logic [31:0] overflow_tally;
   int          mode_items[8];
   int          csr_writes;
   int          quiet_cycles;
   int          stall_left;

   cifc_req_if req_chan();
   cifc_rsp_if rsp_chan();

   cray_ieee_float_converter dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   cifc_conversion_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .overflow_tally (overflow_tally)
   );

   always #10 clock = ~clock;

   // receiver back-pressure: random bursts of low ready while idling is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 99) < 10) begin
         rsp_chan.ready <= 1'b0;
         stall_left = int'($urandom_range(1, 12)) - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // watchdog: counts cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles with no transfer", quiet_cycles);
         $display("status: fail");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(logic [2:0] mode, logic [63:0] hi, logic [63:0] lo);
      int gap;
      if (idle_on && $urandom_range(0, 99) < 12) begin
         gap = $urandom_range(1, 12);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.mode    <= mode;
      req_chan.word_hi <= hi;
      req_chan.word_lo <= lo;
      mode_items[mode]++;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // sender holds off until every conversion has come back, then lets the pipe settle
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_count_enable(logic value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      csr_writes++;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // random word with its exponent steered toward the edges of the chosen conversion
   function automatic void shape_word(input logic [2:0] mode, output logic [63:0] hi,
                                      output logic [63:0] lo);
      int pick, base;
      hi   = {$urandom, $urandom};
      lo   = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      base = -1;
      case (mode)
         MODE_S_TO_CRAY: begin
            case (pick)
               0, 1: hi[30:23] = 8'hFF;
               2:    hi[30:23] = 8'h00;
               3:    hi[30:23] = 8'h01;
               4:    hi[30:23] = 8'hFE;
               default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
               hi[22:0] = '0;
         end
         MODE_D_TO_CRAY: begin
            case (pick)
               0, 1: hi[62:52] = 11'h7FF;
               2:    hi[62:52] = 11'h000;
               3:    hi[62:52] = 11'h001;
               4:    hi[62:52] = 11'h7FE;
               default: ;
            endcase
            case ($urandom_range(0, 3))
               0: hi[51:0] = '0;
               1: hi[51:0] = '1;
               default: ;
            endcase
         end
         MODE_Q_TO_CRAY: begin
            case (pick)
               0, 1: hi[62:48] = 15'h7FFF;
               2:    hi[62:48] = 15'h0000;
               3:    hi[62:48] = 15'h7FFE;
               4:    hi[62:48] = 15'h7FFD;
               5:    hi[62:48] = 15'h0001;
               default: ;
            endcase
            case ($urandom_range(0, 3))
               0: hi[47:0] = '0;
               1: hi[47:0] = '1;
               default: ;
            endcase
            if ($urandom_range(0, 2) == 0)
               lo = '0;
         end
         MODE_CRAY_TO_S, MODE_CRAY_TO_D, MODE_CRAY_TO_Q: begin
            // underflow edge, overflow edge (single and double only), then the cray infinity exponent
            if (pick < 3)
               base = (mode == MODE_CRAY_TO_S) ? CRAY_BIAS - S_BIAS + 2 :
                      (mode == MODE_CRAY_TO_D) ? CRAY_BIAS - D_BIAS + 2 : 3;
            else if (pick < 6 && mode != MODE_CRAY_TO_Q)
               base = (mode == MODE_CRAY_TO_S) ? CRAY_BIAS - S_BIAS + 1 + S_EXP_MAX :
                                                 CRAY_BIAS - D_BIAS + 1 + D_EXP_MAX;
            else if (pick < 8)
               base = int'(CRAY_EXP_MAX);
            if (base >= 0)
               hi[62:48] = 15'(base + int'($urandom_range(0, 6)) - 3);
            if ($urandom_range(0, 3) == 0)
               hi[47:0] = '1;
         end
         default: ;
      endcase
   endfunction

   initial begin
      logic [2:0]  mode;
      logic [63:0] hi, lo;
      int          r;
      clock               = 1'b0;
      reset               = 1'b1;
      idle_on             = 1'b0;
      stall_left          = 0;
      quiet_cycles        = 0;
      csr_writes          = 0;
      csr_write_en        = 1'b0;
      csr_write_data      = 1'b0;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_S_TO_CRAY;
      req_chan.word_hi    = '0;
      req_chan.word_lo    = '0;
      rsp_chan.ready      = 1'b0;
      foreach (mode_items[k]) mode_items[k] = 0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      write_count_enable(1'b1);

      // directed: field extremes, specials and every conversion code
      send_item(MODE_S_TO_CRAY, 64'h0000_0000_3F80_0000, '0);
      send_item(MODE_S_TO_CRAY, 64'hDEAD_BEEF_7F7F_FFFF, '1);
      send_item(MODE_S_TO_CRAY, 64'h0000_0000_7F80_0000, '0);   // infinity
      send_item(MODE_S_TO_CRAY, 64'h0000_0000_FFC0_0001, '0);   // nan
      send_item(MODE_S_TO_CRAY, 64'hFFFF_FFFF_8000_0001, '0);   // negative denormal
      send_item(MODE_D_TO_CRAY, 64'h3FF0_0000_0000_0000, '0);
      send_item(MODE_D_TO_CRAY, 64'h001F_FFFF_FFFF_FFFF, '0);   // rounding carry
      send_item(MODE_D_TO_CRAY, 64'hFFF0_0000_0000_0000, '0);
      send_item(MODE_D_TO_CRAY, 64'h7FF8_0000_0000_0000, '0);
      send_item(MODE_D_TO_CRAY, 64'h800F_FFFF_FFFF_FFFF, '0);
      send_item(MODE_Q_TO_CRAY, 64'h3FFF_0000_0000_0000, 64'h123);
      send_item(MODE_Q_TO_CRAY, 64'h7FFE_FFFF_FFFF_FFFF, '1);   // beyond cray exponent
      send_item(MODE_Q_TO_CRAY, 64'hFFFD_FFFF_FFFF_FFFF, '0);   // carry past cray exponent
      send_item(MODE_Q_TO_CRAY, 64'h7FFF_0000_0000_0000, 64'h1); // nan only in low half
      send_item(MODE_Q_TO_CRAY, 64'hFFFF_0000_0000_0000, '0);
      send_item(MODE_Q_TO_CRAY, 64'h8000_0000_0000_0000, '1);
      send_item(MODE_CRAY_TO_S, 64'h4081_8000_0000_0000, '0);   // true overflow
      send_item(MODE_CRAY_TO_S, 64'hE000_8000_0000_0000, '0);   // cray infinity, no flag
      send_item(MODE_CRAY_TO_S, 64'h4080_FFFF_FFFF_FFFF, '0);
      send_item(MODE_CRAY_TO_S, 64'h3F82_FFFF_FFFF_FFFF, '0);   // underflow
      send_item(MODE_CRAY_TO_D, 64'h4401_8000_0000_0000, '1);
      send_item(MODE_CRAY_TO_D, 64'h7FFF_FFFF_FFFF_FFFF, '0);   // cray nan
      send_item(MODE_CRAY_TO_D, 64'hBC02_8000_0000_0000, '0);
      send_item(MODE_CRAY_TO_Q, 64'h6000_8000_0000_0000, '0);
      send_item(MODE_CRAY_TO_Q, 64'h8002_FFFF_FFFF_FFFF, '0);
      send_item(MODE_CRAY_TO_Q, 64'h0003_7FFF_FFFF_FFFF, '0);
      send_item(MODE_CRAY_TO_Q, 64'h5FFF_FFFF_FFFF_FFFF, '0);
      send_item(MODE_SPARE_LO, '1, '1);
      send_item(MODE_SPARE_HI, '1, '1);

      // random phases, counting toggled between them while the pipe is empty
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         write_count_enable(phase[0]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // idling switched per stretch; the tail of the last phase runs flat out
            if (i % 50 == 0)
               idle_on = (phase == PHASE_COUNT - 1 && i >= PHASE_ITEMS / 2) ? 1'b0 :
                         ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 2)
               mode = (r == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
            else
               mode = 3'($urandom_range(0, 5));
            shape_word(mode, hi, lo);
            send_item(mode, hi, lo);
         end
      end

      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);

      $display("sent %0d single, %0d double, %0d quad to cray; %0d, %0d, %0d back; %0d spare",
               mode_items[0], mode_items[1], mode_items[2], mode_items[3],
               mode_items[4], mode_items[5], mode_items[6] + mode_items[7]);
      $display("checked %0d results, %0d counted overflows, %0d counter enable writes",
               checked_count, overflow_tally, csr_writes);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
